FILE: src/haptic_rumble_packet_encoder_macros.svh
// assertion helpers used by the checker module
`ifndef HAPTIC_RUMBLE_PACKET_ENCODER_MACROS_SVH
`define HAPTIC_RUMBLE_PACKET_ENCODER_MACROS_SVH

// same-cycle implication, off while reset is held
`define HRPE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define HRPE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs through reset
`define HRPE_ASSERT_RST(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/hrpe_pkg.sv
package hrpe_pkg;

  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CODE_W    = 7;
  localparam int unsigned CFG_IDX_W = 3;

  // log unit geometry: operand, integer part, fraction, mantissa
  localparam int unsigned LOGX_W   = 33;
  localparam int unsigned TOP_W    = 6;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned LOG_W    = TOP_W + FRAC_W;
  localparam int unsigned MANT_W   = 32;
  localparam int unsigned SQ_STEPS = FRAC_W;
  localparam int unsigned LOG_LAT  = SQ_STEPS + 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_AMP_FLOOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_AMP_CEIL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HIGH_FLOOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HIGH_CEIL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOW_FLOOR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOW_CEIL     = 3'd5;

  // amplitude break points, Q1.15
  localparam logic [FIELD_W-1:0] AMP_ZERO_MAX  = 16'd251;
  localparam logic [FIELD_W-1:0] AMP_TWO_MAX   = 16'd387;
  localparam logic [FIELD_W-1:0] AMP_LOG4_MAX  = 16'd3686;
  localparam logic [FIELD_W-1:0] AMP_LOG16_MAX = 16'd7372;

  localparam int unsigned AMP_K_W = 21;
  localparam logic [AMP_K_W-1:0] AMP_K_LOG4  = 21'd1196128;
  localparam logic [AMP_K_W-1:0] AMP_K_LOG16 = 21'd170256;
  localparam logic [AMP_K_W-1:0] AMP_K_LOG32 = 21'd8699;

  localparam logic [CODE_W-1:0] AMP_TWO_CODE = 7'd2;
  localparam logic [1:0]        BYTE3_TAG    = 2'b01;

  // rounding shifts for the scales 32, 4, 16, 32
  localparam logic [2:0] SH_FREQ  = 3'd5;
  localparam logic [2:0] SH_LOG4  = 3'd2;
  localparam logic [2:0] SH_LOG16 = 3'd4;
  localparam logic [2:0] SH_LOG32 = 3'd5;

  typedef enum logic [2:0] {
    RGN_ZERO,
    RGN_TWO,
    RGN_LOG4,
    RGN_LOG16,
    RGN_LOG32
  } amp_rgn_t;

  typedef struct packed {
    logic [FIELD_W-1:0] amp_floor;
    logic [FIELD_W-1:0] amp_ceiling;
    logic [FIELD_W-1:0] high_band_floor;
    logic [FIELD_W-1:0] high_band_ceiling;
    logic [FIELD_W-1:0] low_band_floor;
    logic [FIELD_W-1:0] low_band_ceiling;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    amp_floor:         16'd0,
    amp_ceiling:       16'd32768,
    high_band_floor:   16'd1308,
    high_band_ceiling: 16'd20041,
    low_band_floor:    16'd654,
    low_band_ceiling:  16'd10021
  };

  // per-beat flags that travel beside the log lanes
  typedef struct packed {
    logic     hf_zero;
    logic     lf_zero;
    amp_rgn_t ha_rgn;
    amp_rgn_t la_rgn;
  } side_t;

  typedef struct packed {
    logic [BYTE_W-1:0] word_byte0;
    logic [BYTE_W-1:0] word_byte1;
    logic [BYTE_W-1:0] word_byte2;
    logic [BYTE_W-1:0] word_byte3;
  } word_t;

  // Q16 log2 by repeated squaring, elaboration-time only
  function automatic logic [LOG_W-1:0] log2_q16_f(input logic [63:0] x);
    logic [5:0]        top;
    logic [63:0]       y;
    logic [FRAC_W-1:0] frac;
    top = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) top = 6'(i);
    end
    if (top >= 6'd31) y = x >> (top - 6'd31);
    else y = x << (6'd31 - top);
    frac = '0;
    for (int k = 0; k < FRAC_W; k++) begin
      y = (y * y) >> 31;
      frac = {frac[FRAC_W-2:0], 1'b0};
      if (y >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        y = y >> 1;
      end
    end
    return {top, frac};
  endfunction

  localparam logic [LOG_W-1:0] LOG_HIGH_BASE  = log2_q16_f(64'd1280);
  localparam logic [LOG_W-1:0] LOG_LOW_BASE   = log2_q16_f(64'd640);
  localparam logic [LOG_W-1:0] LOG_AMP_BASE_A = log2_q16_f(64'd327680000);
  localparam logic [LOG_W-1:0] LOG_AMP_BASE_B = log2_q16_f(64'd32768000);

endpackage

FILE: src/hrpe_if.sv
interface hrpe_in_if import hrpe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] high_frequency;
  logic [FIELD_W-1:0] low_frequency;
  logic [FIELD_W-1:0] high_amplitude;
  logic [FIELD_W-1:0] low_amplitude;

  modport source (
    output valid, high_frequency, low_frequency, high_amplitude, low_amplitude,
    input  ready
  );
  modport sink (
    input  valid, high_frequency, low_frequency, high_amplitude, low_amplitude,
    output ready
  );
endinterface

interface hrpe_out_if import hrpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] word_byte0;
  logic [BYTE_W-1:0] word_byte1;
  logic [BYTE_W-1:0] word_byte2;
  logic [BYTE_W-1:0] word_byte3;

  modport source (
    output valid, word_byte0, word_byte1, word_byte2, word_byte3,
    input  ready
  );
  modport sink (
    input  valid, word_byte0, word_byte1, word_byte2, word_byte3,
    output ready
  );
endinterface

FILE: src/hrpe_cfg_regs.sv
module hrpe_cfg_regs import hrpe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_AMP_FLOOR:  cfg_nxt.amp_floor         = cfg_wdata;
        CFG_IDX_AMP_CEIL:   cfg_nxt.amp_ceiling       = cfg_wdata;
        CFG_IDX_HIGH_FLOOR: cfg_nxt.high_band_floor   = cfg_wdata;
        CFG_IDX_HIGH_CEIL:  cfg_nxt.high_band_ceiling = cfg_wdata;
        CFG_IDX_LOW_FLOOR:  cfg_nxt.low_band_floor    = cfg_wdata;
        CFG_IDX_LOW_CEIL:   cfg_nxt.low_band_ceiling  = cfg_wdata;
        default: ;  // unused indexes drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: src/hrpe_log2_pipe.sv
module hrpe_log2_pipe import hrpe_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [LOGX_W-1:0] x,
  output logic [LOG_W-1:0]  lg
);

  localparam int unsigned EXT_W = LOGX_W + MANT_W - 1;

  // leading one
  logic [TOP_W-1:0]  top_nxt;
  logic [TOP_W-1:0]  top_r;
  logic [LOGX_W-1:0] x_r;

  always_comb begin
    top_nxt = '0;
    for (int i = 0; i < LOGX_W; i++) begin
      if (x[i]) top_nxt = TOP_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x;
      top_r <= top_nxt;
    end
  end

  // normalise to [1,2) with 31 fraction bits
  logic [EXT_W-1:0]  ext;
  logic [MANT_W-1:0] norm;

  assign ext  = {x_r, {(MANT_W-1){1'b0}}};
  assign norm = MANT_W'(ext >> top_r);

  logic [MANT_W-1:0] sq_y_r   [SQ_STEPS+1];
  logic [TOP_W-1:0]  sq_top_r [SQ_STEPS+1];
  logic [FRAC_W-1:0] sq_frac_r [1:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_y_r[0]   <= norm;
      sq_top_r[0] <= top_r;
    end
  end

  // one squaring per stage, one fraction bit each
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    logic [2*MANT_W-1:0] prod;
    logic [MANT_W:0]     q;
    logic [FRAC_W-1:0]   frac_in;

    if (k == 0) begin : g_first
      assign frac_in = '0;
    end else begin : g_rest
      assign frac_in = sq_frac_r[k];
    end

    assign prod = sq_y_r[k] * sq_y_r[k];
    assign q    = prod[2*MANT_W-1:MANT_W-1];

    always_ff @(posedge clk) begin
      if (en) begin
        sq_y_r[k+1]    <= q[MANT_W] ? q[MANT_W:1] : q[MANT_W-1:0];
        sq_frac_r[k+1] <= {frac_in[FRAC_W-2:0], q[MANT_W]};
        sq_top_r[k+1]  <= sq_top_r[k];
      end
    end
  end

  assign lg = {sq_top_r[SQ_STEPS], sq_frac_r[SQ_STEPS]};

endmodule

FILE: src/hrpe_code_pack.sv
module hrpe_code_pack import hrpe_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [LOG_W-1:0] log_hf,
  input  logic [LOG_W-1:0] log_lf,
  input  logic [LOG_W-1:0] log_ha,
  input  logic [LOG_W-1:0] log_la,
  input  side_t            side,
  output word_t            word
);

  localparam int unsigned M_W = LOG_W + 6;
  localparam int unsigned V_W = M_W - FRAC_W;

  // round (d * 2^sh) / 2^16 to nearest, clip to 0..127
  function automatic logic [CODE_W-1:0] log_code(
    input logic [LOG_W-1:0] lg,
    input logic [LOG_W-1:0] base,
    input logic [2:0]       sh
  );
    logic [LOG_W:0]      d;
    logic [M_W-1:0]      m;
    logic [V_W-1:0]      v;
    logic [CODE_W-1:0]   code;
    d = {1'b0, lg} - {1'b0, base};
    m = (M_W'(d[LOG_W-1:0]) << sh) + M_W'(32'd32768);
    v = m[M_W-1:FRAC_W];
    if (d[LOG_W] || (d == '0)) code = '0;
    else if (|v[V_W-1:CODE_W]) code = '1;
    else code = v[CODE_W-1:0];
    return code;
  endfunction

  function automatic logic [CODE_W-1:0] amp_code(
    input amp_rgn_t         rgn,
    input logic [LOG_W-1:0] lg
  );
    logic [CODE_W-1:0] code;
    case (rgn)
      RGN_ZERO:  code = '0;
      RGN_TWO:   code = AMP_TWO_CODE;
      RGN_LOG4:  code = log_code(lg, LOG_AMP_BASE_A, SH_LOG4);
      RGN_LOG16: code = log_code(lg, LOG_AMP_BASE_A, SH_LOG16);
      RGN_LOG32: code = log_code(lg, LOG_AMP_BASE_B, SH_LOG32);
      default:   code = '0;
    endcase
    return code;
  endfunction

  logic [CODE_W-1:0] fh;
  logic [CODE_W-1:0] fl;
  logic [CODE_W-1:0] ah;
  logic [CODE_W-1:0] al;
  word_t             word_nxt;
  word_t             word_r;

  assign fh = side.hf_zero ? '0 : log_code(log_hf, LOG_HIGH_BASE, SH_FREQ);
  assign fl = side.lf_zero ? '0 : log_code(log_lf, LOG_LOW_BASE, SH_FREQ);
  assign ah = amp_code(side.ha_rgn, log_ha);
  assign al = amp_code(side.la_rgn, log_la);

  always_comb begin
    word_nxt.word_byte0 = {fh[CODE_W-2:0], 2'b00};
    word_nxt.word_byte1 = {ah, fh[CODE_W-1]};
    word_nxt.word_byte2 = {al[0], fl};
    word_nxt.word_byte3 = {BYTE3_TAG, al[CODE_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign word = word_r;

endmodule

FILE: src/hrpe_out_skid.sv
module hrpe_out_skid import hrpe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pipe_valid,
  input  word_t             pipe_word,
  output logic              en,
  hrpe_out_if.source        out_ch
);

  logic  out_valid_r;
  logic  out_valid_nxt;
  word_t out_word_r;
  word_t out_word_nxt;
  logic  skid_full_r;
  logic  skid_full_nxt;
  word_t skid_word_r;
  word_t skid_word_nxt;
  logic  take;

  assign take = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    skid_full_nxt = skid_full_r;
    skid_word_nxt = skid_word_r;
    if (take) begin
      if (skid_full_r) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = skid_word_r;
        skid_full_nxt = 1'b0;
      end else begin
        out_valid_nxt = pipe_valid;
        out_word_nxt  = pipe_word;
      end
    end else if (pipe_valid && !skid_full_r) begin
      // output stalled, park the arriving beat
      skid_full_nxt = 1'b1;
      skid_word_nxt = pipe_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  assign en                = !skid_full_r;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.word_byte0 = out_word_r.word_byte0;
  assign out_ch.word_byte1 = out_word_r.word_byte1;
  assign out_ch.word_byte2 = out_word_r.word_byte2;
  assign out_ch.word_byte3 = out_word_r.word_byte3;

endmodule

FILE: src/haptic_rumble_packet_encoder.sv
// channel | dir | beat contents
// --------+-----+-------------------------------------------------------------
// in_ch   | in  | high_frequency, low_frequency (Q12.4 Hz), high/low_amplitude
// out_ch  | out | word_byte0..word_byte3, the packed vibration word
// cfg_*   | in  | cfg_we, cfg_index, cfg_wdata: six 16-bit clamp limits
//
// one beat per cycle sustained while out_ch keeps taking beats; the path from in_ch to
// out_ch is set by the sixteen squaring stages of each log lane plus front and back end
// rst_n is synchronous, active low: empties the pipe and skid, loads the limits
// an out_ch stall parks one beat in the skid register; in_ch.ready drops only while
// the skid is full and comes back the cycle after out_ch takes a beat
module haptic_rumble_packet_encoder import hrpe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_wdata,
  hrpe_in_if.sink              in_ch,
  hrpe_out_if.source           out_ch
);

  // clamp: raise to floor first, then lower to ceiling, so the ceiling wins
  function automatic logic [FIELD_W-1:0] clamp(
    input logic [FIELD_W-1:0] v,
    input logic [FIELD_W-1:0] lo,
    input logic [FIELD_W-1:0] hi
  );
    logic [FIELD_W-1:0] r;
    r = (v < lo) ? lo : v;
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic amp_rgn_t amp_region(input logic [FIELD_W-1:0] a);
    amp_rgn_t r;
    if (a <= AMP_ZERO_MAX) r = RGN_ZERO;
    else if (a <= AMP_TWO_MAX) r = RGN_TWO;
    else if (a <= AMP_LOG4_MAX) r = RGN_LOG4;
    else if (a <= AMP_LOG16_MAX) r = RGN_LOG16;
    else r = RGN_LOG32;
    return r;
  endfunction

  // gain ahead of the log; the two low regions never use the result
  function automatic logic [AMP_K_W-1:0] amp_gain(input amp_rgn_t r);
    logic [AMP_K_W-1:0] k;
    case (r)
      RGN_LOG16: k = AMP_K_LOG16;
      RGN_LOG32: k = AMP_K_LOG32;
      default:   k = AMP_K_LOG4;
    endcase
    return k;
  endfunction

  logic en;
  cfg_t cfg;

  hrpe_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_ch.ready = en;

  // stage 1: input register
  logic               vld_s1_r;
  logic [FIELD_W-1:0] hf_s1_r;
  logic [FIELD_W-1:0] lf_s1_r;
  logic [FIELD_W-1:0] ha_s1_r;
  logic [FIELD_W-1:0] la_s1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hf_s1_r <= in_ch.high_frequency;
      lf_s1_r <= in_ch.low_frequency;
      ha_s1_r <= in_ch.high_amplitude;
      la_s1_r <= in_ch.low_amplitude;
    end
  end

  // stage 2: clamp and sort amplitudes into their break-point regions
  logic               vld_s2_r;
  logic [FIELD_W-1:0] hf_s2_nxt;
  logic [FIELD_W-1:0] lf_s2_nxt;
  logic [FIELD_W-1:0] ha_s2_nxt;
  logic [FIELD_W-1:0] la_s2_nxt;
  logic [FIELD_W-1:0] hf_s2_r;
  logic [FIELD_W-1:0] lf_s2_r;
  logic [FIELD_W-1:0] ha_s2_r;
  logic [FIELD_W-1:0] la_s2_r;
  side_t              side_s2_nxt;
  side_t              side_s2_r;

  always_comb begin
    hf_s2_nxt = clamp(hf_s1_r, cfg.high_band_floor, cfg.high_band_ceiling);
    lf_s2_nxt = clamp(lf_s1_r, cfg.low_band_floor, cfg.low_band_ceiling);
    ha_s2_nxt = clamp(ha_s1_r, cfg.amp_floor, cfg.amp_ceiling);
    la_s2_nxt = clamp(la_s1_r, cfg.amp_floor, cfg.amp_ceiling);
    side_s2_nxt.hf_zero = (hf_s2_nxt == '0);
    side_s2_nxt.lf_zero = (lf_s2_nxt == '0);
    side_s2_nxt.ha_rgn  = amp_region(ha_s2_nxt);
    side_s2_nxt.la_rgn  = amp_region(la_s2_nxt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hf_s2_r   <= hf_s2_nxt;
      lf_s2_r   <= lf_s2_nxt;
      ha_s2_r   <= ha_s2_nxt;
      la_s2_r   <= la_s2_nxt;
      side_s2_r <= side_s2_nxt;
    end
  end

  // stage 3: log operands; amplitude products stay inside 33 bits per region
  logic [FIELD_W+AMP_K_W-1:0] ha_prod;
  logic [FIELD_W+AMP_K_W-1:0] la_prod;
  logic [LOGX_W-1:0]          x_hf_r;
  logic [LOGX_W-1:0]          x_lf_r;
  logic [LOGX_W-1:0]          x_ha_r;
  logic [LOGX_W-1:0]          x_la_r;

  assign ha_prod = ha_s2_r * amp_gain(side_s2_r.ha_rgn);
  assign la_prod = la_s2_r * amp_gain(side_s2_r.la_rgn);

  always_ff @(posedge clk) begin
    if (en) begin
      x_hf_r <= LOGX_W'(hf_s2_r);
      x_lf_r <= LOGX_W'(lf_s2_r);
      x_ha_r <= ha_prod[LOGX_W-1:0];
      x_la_r <= la_prod[LOGX_W-1:0];
    end
  end

  // four log lanes
  logic [LOG_W-1:0] log_hf;
  logic [LOG_W-1:0] log_lf;
  logic [LOG_W-1:0] log_ha;
  logic [LOG_W-1:0] log_la;

  hrpe_log2_pipe u_log_hf (.clk(clk), .en(en), .x(x_hf_r), .lg(log_hf));
  hrpe_log2_pipe u_log_lf (.clk(clk), .en(en), .x(x_lf_r), .lg(log_lf));
  hrpe_log2_pipe u_log_ha (.clk(clk), .en(en), .x(x_ha_r), .lg(log_ha));
  hrpe_log2_pipe u_log_la (.clk(clk), .en(en), .x(x_la_r), .lg(log_la));

  // flags and valids ride alongside the lanes; entry 0 is stage 3
  side_t side_dly_r [LOG_LAT+1];
  logic  vld_dly_r  [LOG_LAT+1];
  logic  vld_code_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side_dly_r[0] <= side_s2_r;
      for (int k = 1; k <= LOG_LAT; k++) begin
        side_dly_r[k] <= side_dly_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s1_r   <= 1'b0;
      vld_s2_r   <= 1'b0;
      vld_code_r <= 1'b0;
      for (int k = 0; k <= LOG_LAT; k++) begin
        vld_dly_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_s1_r     <= in_ch.valid;
      vld_s2_r     <= vld_s1_r;
      vld_dly_r[0] <= vld_s2_r;
      for (int k = 1; k <= LOG_LAT; k++) begin
        vld_dly_r[k] <= vld_dly_r[k-1];
      end
      vld_code_r   <= vld_dly_r[LOG_LAT];
    end
  end

  // codes and byte packing, registered
  word_t word_code;

  hrpe_code_pack u_code_pack (
    .clk    (clk),
    .en     (en),
    .log_hf (log_hf),
    .log_lf (log_lf),
    .log_ha (log_ha),
    .log_la (log_la),
    .side   (side_dly_r[LOG_LAT]),
    .word   (word_code)
  );

  // output register with one skid entry; its fill state gates the whole pipe
  hrpe_out_skid u_out_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_valid (vld_code_r),
    .pipe_word  (word_code),
    .en         (en),
    .out_ch     (out_ch)
  );

endmodule

FILE: src/hrpe_checker.sv
`include "haptic_rumble_packet_encoder_macros.svh"

module hrpe_checker import hrpe_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_word_byte0,
  input logic [BYTE_W-1:0] out_word_byte1,
  input logic [BYTE_W-1:0] out_word_byte2,
  input logic [BYTE_W-1:0] out_word_byte3
);

  // back-pressure on the input only while a result is held
  `HRPE_ASSERT_IMP(a_stall_needs_result, clk, rst_n, !in_ready, out_valid, "input stalled with no result held")

  // a taken beat frees the skid, so input opens again next cycle
  `HRPE_ASSERT_NXT(a_stall_clears, clk, rst_n, !in_ready && out_ready, in_ready, "input stall outlived a taken beat")

  // held result keeps its valid and bytes
  `HRPE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word_byte0) && $stable(out_word_byte1) && $stable(out_word_byte2) && $stable(out_word_byte3), "stalled result changed")

  // fixed bits of the packed word
  `HRPE_ASSERT_IMP(a_pack_tag, clk, rst_n, out_valid, (out_word_byte3[7:6] == BYTE3_TAG) && (out_word_byte0[1:0] == 2'b00), "fixed word bits wrong")

  // reset empties the output side and opens the input
  `HRPE_ASSERT_RST(a_reset_empty, clk, !rst_n, !out_valid && in_ready, "output not empty after reset")

endmodule

bind haptic_rumble_packet_encoder hrpe_checker u_hrpe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_word_byte0 (out_ch.word_byte0),
  .out_word_byte1 (out_ch.word_byte1),
  .out_word_byte2 (out_ch.word_byte2),
  .out_word_byte3 (out_ch.word_byte3)
);

FILE: dv/rumble_word_pkg.sv
package rumble_word_pkg;
  import hrpe_pkg::*;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE7 = 3'd7;

  // reference points: 80 Hz and 40 Hz in Q12.4, amplitude scale denominators
  localparam longint unsigned HIGH_REF_Q4  = 64'd1280;
  localparam longint unsigned LOW_REF_Q4   = 64'd640;
  localparam longint unsigned AMP_DEN_NEAR = 64'd327680000;
  localparam longint unsigned AMP_DEN_FAR  = 64'd32768000;

  // amplitude break points and slope multipliers
  localparam int unsigned AMP_NIL_TOP   = 251;
  localparam int unsigned AMP_TWO_TOP   = 387;
  localparam int unsigned AMP_STEEP_TOP = 3686;
  localparam int unsigned AMP_MID_TOP   = 7372;
  localparam longint unsigned MUL_STEEP = 64'd1196128;
  localparam longint unsigned MUL_MID   = 64'd170256;
  localparam longint unsigned MUL_FLAT  = 64'd8699;

  localparam logic [CODE_W-1:0] CODE_TWO  = 7'd2;
  localparam logic [BYTE_W-1:0] WORD3_TAG = 8'h40;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [FIELD_W-1:0] high_frequency;
    logic [FIELD_W-1:0] low_frequency;
    logic [FIELD_W-1:0] high_amplitude;
    logic [FIELD_W-1:0] low_amplitude;
  } rumble_req_t;

  class word_board;
    cfg_t        limits;
    word_t       expected_words[$];
    int unsigned faults;
    int unsigned reported;

    function new();
      limits.amp_floor         = 16'd0;
      limits.amp_ceiling       = 16'd32768;
      limits.high_band_floor   = 16'd1308;
      limits.high_band_ceiling = 16'd20041;
      limits.low_band_floor    = 16'd654;
      limits.low_band_ceiling  = 16'd10021;
      faults   = 0;
      reported = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
      case (idx)
        CFG_IDX_AMP_FLOOR:  limits.amp_floor         = val;
        CFG_IDX_AMP_CEIL:   limits.amp_ceiling       = val;
        CFG_IDX_HIGH_FLOOR: limits.high_band_floor   = val;
        CFG_IDX_HIGH_CEIL:  limits.high_band_ceiling = val;
        CFG_IDX_LOW_FLOOR:  limits.low_band_floor    = val;
        CFG_IDX_LOW_CEIL:   limits.low_band_ceiling  = val;
        default: ;
      endcase
    endfunction

    // floor first, ceiling last
    static function logic [FIELD_W-1:0] clamp(logic [FIELD_W-1:0] v,
                                              logic [FIELD_W-1:0] lo,
                                              logic [FIELD_W-1:0] hi);
      logic [FIELD_W-1:0] r;
      r = (v < lo) ? lo : v;
      return (r > hi) ? hi : r;
    endfunction

    // log2 in Q16 by repeated squaring of the normalised mantissa
    static function int log2_fixed(longint unsigned x);
      int unsigned     msb;
      longint unsigned m;
      int unsigned     frac;
      msb = 0;
      m = x;
      while (m > 64'd1) begin
        m = m >> 1;
        msb++;
      end
      m = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
      frac = 0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m[32]) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      return int'((msb << 16) | frac);
    endfunction

    static function logic [CODE_W-1:0] round_code(int d, int unsigned scale);
      longint unsigned v;
      if (d <= 0) return '0;
      v = (longint'(d) * scale + 64'd32768) >> 16;
      return (v > 64'd127) ? 7'd127 : v[CODE_W-1:0];
    endfunction

    static function logic [CODE_W-1:0] freq_code(logic [FIELD_W-1:0] f,
                                                 longint unsigned ref_q4);
      if (f == '0) return '0;
      return round_code(log2_fixed(longint'(f)) - log2_fixed(ref_q4), 32);
    endfunction

    static function logic [CODE_W-1:0] amp_code(logic [FIELD_W-1:0] a);
      longint unsigned av;
      av = longint'(a);
      if (a <= AMP_NIL_TOP) return '0;
      if (a <= AMP_TWO_TOP) return CODE_TWO;
      if (a <= AMP_STEEP_TOP)
        return round_code(log2_fixed(av * MUL_STEEP) - log2_fixed(AMP_DEN_NEAR), 4);
      if (a <= AMP_MID_TOP)
        return round_code(log2_fixed(av * MUL_MID) - log2_fixed(AMP_DEN_NEAR), 16);
      return round_code(log2_fixed(av * MUL_FLAT) - log2_fixed(AMP_DEN_FAR), 32);
    endfunction

    function word_t encode_word(rumble_req_t r);
      logic [CODE_W-1:0] fh, fl, ah, al;
      word_t w;
      fh = freq_code(clamp(r.high_frequency, limits.high_band_floor,
                           limits.high_band_ceiling), HIGH_REF_Q4);
      fl = freq_code(clamp(r.low_frequency, limits.low_band_floor,
                           limits.low_band_ceiling), LOW_REF_Q4);
      ah = amp_code(clamp(r.high_amplitude, limits.amp_floor, limits.amp_ceiling));
      al = amp_code(clamp(r.low_amplitude, limits.amp_floor, limits.amp_ceiling));
      w.word_byte0 = {fh[5:0], 2'b00};
      w.word_byte1 = {ah, fh[6]};
      w.word_byte2 = {al[0], fl};
      w.word_byte3 = WORD3_TAG + BYTE_W'(al >> 1);
      return w;
    endfunction

    function void note_request(rumble_req_t r);
      expected_words.push_back(encode_word(r));
    endfunction

    function void check_word(word_t got);
      word_t want;
      if (expected_words.size() == 0) begin
        faults++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("unexpected word %h with nothing pending", got);
        end
        return;
      end
      want = expected_words.pop_front();
      if (got.word_byte0 !== want.word_byte0 || got.word_byte1 !== want.word_byte1 ||
          got.word_byte2 !== want.word_byte2 || got.word_byte3 !== want.word_byte3) begin
        faults++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("word mismatch: expected %h %h %h %h, got %h %h %h %h",
                   want.word_byte0, want.word_byte1, want.word_byte2, want.word_byte3,
                   got.word_byte0, got.word_byte1, got.word_byte2, got.word_byte3);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

endpackage

FILE: dv/tb_top.sv
module tb_top;
  import hrpe_pkg::*;
  import rumble_word_pkg::*;

  // receiver hold-off long enough to fill the pipe and the skid
  localparam int HOLD_CYCLES = 80;
  // latency plus skid, waited out after the last word
  localparam int TAIL_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0]   cfg_wdata;

  hrpe_in_if  in_ch();
  hrpe_out_if out_ch();

  word_board board = new();

  // calm: no idling on either side for a stretch
  bit calm;
  // set by the stimulus, taken by the receiver process
  bit hold_off_req;

  haptic_rumble_packet_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #6000000;
    $display("tb_top failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // frequencies: whole range, around the band edges, near zero
  function automatic logic [FIELD_W-1:0] rand_freq();
    case ($urandom_range(0, 3))
      0:       return FIELD_W'($urandom);
      1:       return FIELD_W'($urandom_range(0, 2000));
      2:       return FIELD_W'($urandom_range(600, 20100));
      default: return FIELD_W'($urandom_range(0, 40));
    endcase
  endfunction

  // amplitudes: whole range and each region of the piecewise rule
  function automatic logic [FIELD_W-1:0] rand_amp();
    case ($urandom_range(0, 4))
      0:       return FIELD_W'($urandom);
      1:       return FIELD_W'($urandom_range(0, 420));
      2:       return FIELD_W'($urandom_range(380, 3700));
      3:       return FIELD_W'($urandom_range(3680, 7400));
      default: return FIELD_W'($urandom_range(7360, 40000));
    endcase
  endfunction

  function automatic rumble_req_t make_req(logic [FIELD_W-1:0] hf, logic [FIELD_W-1:0] lf,
                                           logic [FIELD_W-1:0] ha, logic [FIELD_W-1:0] la);
    rumble_req_t r;
    r.high_frequency = hf;
    r.low_frequency  = lf;
    r.high_amplitude = ha;
    r.low_amplitude  = la;
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] rand_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // random limits, usually ordered floor below ceiling
  function automatic cfg_t rand_limits();
    cfg_t c;
    logic [FIELD_W-1:0] t;
    c.amp_floor         = rand_limit();
    c.amp_ceiling       = rand_limit();
    c.high_band_floor   = rand_limit();
    c.high_band_ceiling = rand_limit();
    c.low_band_floor    = rand_limit();
    c.low_band_ceiling  = rand_limit();
    if ($urandom_range(0, 2) != 0) begin
      if (c.amp_floor > c.amp_ceiling) begin
        t = c.amp_floor; c.amp_floor = c.amp_ceiling; c.amp_ceiling = t;
      end
      if (c.high_band_floor > c.high_band_ceiling) begin
        t = c.high_band_floor; c.high_band_floor = c.high_band_ceiling;
        c.high_band_ceiling = t;
      end
      if (c.low_band_floor > c.low_band_ceiling) begin
        t = c.low_band_floor; c.low_band_floor = c.low_band_ceiling;
        c.low_band_ceiling = t;
      end
    end
    return c;
  endfunction

  // back-to-back register writes; cfg_we stays high across the burst
  task automatic load_limits(input cfg_t c, input bit poke_spare);
    logic [CFG_IDX_W-1:0] idx [8];
    logic [FIELD_W-1:0]   val [8];
    int n;
    idx[0] = CFG_IDX_AMP_FLOOR;  val[0] = c.amp_floor;
    idx[1] = CFG_IDX_AMP_CEIL;   val[1] = c.amp_ceiling;
    idx[2] = CFG_IDX_HIGH_FLOOR; val[2] = c.high_band_floor;
    idx[3] = CFG_IDX_HIGH_CEIL;  val[3] = c.high_band_ceiling;
    idx[4] = CFG_IDX_LOW_FLOOR;  val[4] = c.low_band_floor;
    idx[5] = CFG_IDX_LOW_CEIL;   val[5] = c.low_band_ceiling;
    // spare indexes must leave every limit alone
    idx[6] = CFG_IDX_SPARE6;     val[6] = FIELD_W'($urandom);
    idx[7] = CFG_IDX_SPARE7;     val[7] = FIELD_W'($urandom);
    n = poke_spare ? 8 : 6;
    for (int i = 0; i < n; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      board.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // one beat: optional gap, then hold valid until the block takes it
  task automatic send_req(input rumble_req_t r);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.high_frequency <= r.high_frequency;
    in_ch.low_frequency  <= r.low_frequency;
    in_ch.high_amplitude <= r.high_amplitude;
    in_ch.low_amplitude  <= r.low_amplitude;
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(r);
  endtask

  // random beats; calm stretches come and go, optional long receiver hold-offs
  task automatic send_random(input int n, input bit with_holds);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (with_holds && (i == 100 || i == 220)) hold_off_req = 1'b1;
      send_req(make_req(rand_freq(), rand_freq(), rand_amp(), rand_amp()));
    end
    in_ch.valid <= 1'b0;
  endtask

  // every expected word back before the limits move
  task automatic drain();
    while (board.pending() != 0) @(posedge clk);
  endtask

  // receiver: random ready pattern, or a long hold-off when asked
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // result side: every beat taken goes to the board
  always @(posedge clk) begin
    word_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.word_byte0 = out_ch.word_byte0;
      got.word_byte1 = out_ch.word_byte1;
      got.word_byte2 = out_ch.word_byte2;
      got.word_byte3 = out_ch.word_byte3;
      board.check_word(got);
    end
  end

  initial begin
    cfg_t c;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.high_frequency <= '0;
    in_ch.low_frequency  <= '0;
    in_ch.high_amplitude <= '0;
    in_ch.low_amplitude  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // limits as they come out of reset
    send_random(40, 1'b0);
    drain();

    // wide open limits, spare indexes poked as well
    c.amp_floor         = '0;
    c.amp_ceiling       = '1;
    c.high_band_floor   = '0;
    c.high_band_ceiling = '1;
    c.low_band_floor    = '0;
    c.low_band_ceiling  = '1;
    load_limits(c, 1'b1);

    // corners: zero and full scale fields, zero frequency, amplitude break points,
    // frequencies at and around 80 Hz and 40 Hz, alternating bit patterns
    send_req(make_req(16'd0, 16'd0, 16'd0, 16'd0));
    send_req(make_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_req(make_req(16'd0, 16'd640, 16'd251, 16'd252));
    send_req(make_req(16'd1280, 16'd0, 16'd387, 16'd388));
    send_req(make_req(16'd1279, 16'd639, 16'd3686, 16'd3687));
    send_req(make_req(16'd1281, 16'd641, 16'd7372, 16'd7373));
    send_req(make_req(16'd20041, 16'd10021, 16'd32768, 16'd32767));
    send_req(make_req(16'd1308, 16'd654, 16'd1, 16'd0));
    send_req(make_req(16'd1, 16'd1, 16'd7373, 16'd251));
    send_req(make_req(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    send_req(make_req(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    send_req(make_req(16'd40000, 16'd20000, 16'd40000, 16'd20000));
    send_req(make_req(16'd2560, 16'd1280, 16'd388, 16'd3687));
    send_req(make_req(16'd1000, 16'd500, 16'd16384, 16'd8192));
    send_req(make_req(16'd65535, 16'd2, 16'd65535, 16'd1));
    send_req(make_req(16'd2, 16'd65535, 16'd1, 16'd65535));
    // bulk of the run, with two long receiver hold-offs to back up the pipe
    send_random(300, 1'b1);
    drain();

    // floors above ceilings: the ceilings win
    c.amp_floor         = 16'd40000;
    c.amp_ceiling       = 16'd5000;
    c.high_band_floor   = 16'd50000;
    c.high_band_ceiling = 16'd2000;
    c.low_band_floor    = 16'd30000;
    c.low_band_ceiling  = 16'd700;
    load_limits(c, 1'b0);
    send_random(60, 1'b0);
    drain();

    // everything pinned to zero
    c = '0;
    load_limits(c, 1'b0);
    send_random(30, 1'b0);
    drain();

    // everything pinned to full scale
    c = '1;
    load_limits(c, 1'b0);
    send_random(30, 1'b0);
    drain();

    // random limit sets
    for (int p = 0; p < 3; p++) begin
      load_limits(rand_limits(), 1'b1);
      send_random(70, 1'b0);
      drain();
    end

    // stray words would show up within the pipe latency
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: haptic_rumble_packet_encoder.f
+incdir+src
src/hrpe_pkg.sv
src/hrpe_if.sv
src/hrpe_cfg_regs.sv
src/hrpe_log2_pipe.sv
src/hrpe_code_pack.sv
src/hrpe_out_skid.sv
src/haptic_rumble_packet_encoder.sv
src/hrpe_checker.sv
dv/rumble_word_pkg.sv
dv/tb_top.sv
